FILE: hdl/srsw_pkg.sv
`default_nettype none
package srsw_pkg;

	localparam int MAX_PACKETS  = 256;
	localparam int MAX_WINDOW   = 16;
	localparam int TIMER_BITS   = 16;
	localparam int RESULT_LIMIT = 16;

	localparam int IDX_W   = $clog2(MAX_PACKETS);
	localparam int BASE_W  = $clog2(MAX_PACKETS + 1);
	localparam int END_W   = BASE_W + 1;
	localparam int WIN_CAP = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW : RESULT_LIMIT;

	// sent and acked flags live only for the window, in a ring indexed by sequence low bits
	localparam int SLOT_W     = $clog2(WIN_CAP);
	localparam int RING_DEPTH = 1 << SLOT_W;

	localparam int TOTAL_W   = 9;
	localparam int WINREG_W  = 5;
	localparam int TIMEOUT_W = 16;
	localparam int SEQ_W     = 8;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [TOTAL_W-1:0]   TOTAL_RST   = TOTAL_W'(8);
	localparam logic [WINREG_W-1:0]  WINDOW_RST  = WINREG_W'(4);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(30);

	localparam logic [1:0] REG_TOTAL   = 2'd0;
	localparam logic [1:0] REG_WINDOW  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ACK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACK,
		ST_SLIDE,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_FINISH
	} step_t;

	typedef enum logic [2:0] {
		JC_NONE,
		JC_NO_BEAT,
		JC_TICK,
		JC_SLIDE_MORE,
		JC_SCAN_END,
		JC_OUT_BUSY
	} jcond_t;

	typedef struct packed {
		logic   take_beat;
		logic   ack_upd;
		logic   slide;
		logic   scan_rd;
		logic   scan_ev;
		logic   emit_last;
		jcond_t jc;
		step_t  alt;
		step_t  nxt;
	} uword_t;

	// control store: jump to alt when the condition holds, else go to nxt
	function automatic uword_t ucode(step_t s);
		uword_t w;
		w = '0;
		w.jc = JC_NONE;
		w.alt = ST_IDLE;
		w.nxt = ST_IDLE;
		unique case (s)
			ST_IDLE: begin
				w.take_beat = 1'b1;
				w.jc = JC_NO_BEAT;
				w.alt = ST_IDLE;
				w.nxt = ST_ACK;
			end
			ST_ACK: begin
				w.ack_upd = 1'b1;
				w.jc = JC_TICK;
				w.alt = ST_SCAN_RD;
				w.nxt = ST_SLIDE;
			end
			ST_SLIDE: begin
				w.slide = 1'b1;
				w.jc = JC_SLIDE_MORE;
				w.alt = ST_SLIDE;
				w.nxt = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				w.scan_rd = 1'b1;
				w.jc = JC_SCAN_END;
				w.alt = ST_FINISH;
				w.nxt = ST_SCAN_EV;
			end
			ST_SCAN_EV: begin
				w.scan_ev = 1'b1;
				w.jc = JC_OUT_BUSY;
				w.alt = ST_SCAN_EV;
				w.nxt = ST_SCAN_RD;
			end
			ST_FINISH: begin
				w.emit_last = 1'b1;
				w.jc = JC_OUT_BUSY;
				w.alt = ST_FINISH;
				w.nxt = ST_IDLE;
			end
			default: begin
				w.nxt = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/srsw_req_if.sv
`default_nettype none
interface srsw_req_if;
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [srsw_pkg::SEQ_W-1:0] ack_seq;

	modport source (output valid, output operation, output ack_seq, input ready);
	modport sink (input valid, input operation, input ack_seq, output ready);
endinterface
`default_nettype wire

FILE: hdl/srsw_rsp_if.sv
`default_nettype none
interface srsw_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      send_valid;
	logic [srsw_pkg::SEQ_W-1:0] send_seq;
	logic                      is_retransmit;
	logic                      ack_ignored;
	logic                      all_done;
	logic                      last;

	modport source (
		output valid, output send_valid, output send_seq, output is_retransmit,
		output ack_ignored, output all_done, output last, input ready
	);
	modport sink (
		input valid, input send_valid, input send_seq, input is_retransmit,
		input ack_ignored, input all_done, input last, output ready
	);
endinterface
`default_nettype wire

FILE: hdl/srsw_ram.sv
`default_nettype none
module srsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/selective_repeat_sender_window_core.sv
// sequence: an input beat is taken in the idle step, then a decode step; for an ack the
// base slides over the acked packets, then each window entry is scanned (timer read, then
// evaluate and write back to the timer memory), then closing steps emit the last result
// a new input is taken only when the previous one is finished; the scan stalls while the
// result side is busy; the window holds at most 16 entries
// reset: arst_n clears base and sent/acked flags, loads 8, 4 and 30; timer memory not cleared
`default_nettype none
module selective_repeat_sender_window_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	srsw_req_if.sink                           req,
	srsw_rsp_if.source                         rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [srsw_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [srsw_pkg::DATA_W-1:0]   pwdata,
	output logic      [srsw_pkg::DATA_W-1:0]   prdata,
	output logic                               pready
);

	localparam int IDX_W  = srsw_pkg::IDX_W;
	localparam int BASE_W = srsw_pkg::BASE_W;
	localparam int END_W  = srsw_pkg::END_W;
	localparam int TB     = srsw_pkg::TIMER_BITS;
	localparam int SLOT_W = srsw_pkg::SLOT_W;

	// config registers
	logic [srsw_pkg::TOTAL_W-1:0]   total_q;
	logic [srsw_pkg::WINREG_W-1:0]  win_q;
	logic [srsw_pkg::TIMEOUT_W-1:0] timeout_q;
	logic                           cfg_wr;

	// control state
	srsw_pkg::step_t          step_q, step_d;
	srsw_pkg::uword_t         uw;
	logic [BASE_W-1:0]        base_q;
	logic [srsw_pkg::RING_DEPTH-1:0] acked_q;
	logic [srsw_pkg::RING_DEPTH-1:0] sent_q;
	logic                     out_vld_q;
	logic                     pend_q;

	// payload
	logic                     op_q;
	logic [srsw_pkg::SEQ_W-1:0] seq_q;
	logic                     ign_q;
	logic [BASE_W-1:0]        idx_q;
	logic [IDX_W-1:0]         pend_seq_q;
	logic                     pend_rt_q;
	logic                     o_send_q;
	logic [srsw_pkg::SEQ_W-1:0] o_seq_q;
	logic                     o_rt_q;
	logic                     o_ign_q;
	logic                     o_done_q;
	logic                     o_last_q;

	// datapath
	logic [BASE_W-1:0] eff_total;
	logic [END_W-1:0]  eff_win;
	logic [END_W-1:0]  end_raw;
	logic [END_W-1:0]  win_end;
	logic              done;
	logic              in_win;
	logic              slide_more;
	logic              scan_end;
	logic [IDX_W-1:0]  idx;
	logic [IDX_W-1:0]  seq_idx;
	logic [SLOT_W-1:0] idx_slot;
	logic [SLOT_W-1:0] seq_slot;
	logic [SLOT_W-1:0] base_slot;
	logic [TB-1:0]     t_rd;
	logic [TB-1:0]     t_aged;
	logic              age;
	logic              send_now;
	logic              e_acked;
	logic              e_sent;
	logic              out_free;
	logic              push_req;
	logic              blocked;
	logic              ev_go;
	logic              fin_go;
	logic              jmp;
	logic              beat_in;
	logic              t_we;
	logic [TB-1:0]     t_wdata;
	logic              t_re;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			srsw_pkg::REG_TOTAL:   prdata = srsw_pkg::DATA_W'(total_q);
			srsw_pkg::REG_WINDOW:  prdata = srsw_pkg::DATA_W'(win_q);
			srsw_pkg::REG_TIMEOUT: prdata = srsw_pkg::DATA_W'(timeout_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= srsw_pkg::TOTAL_RST;
			win_q <= srsw_pkg::WINDOW_RST;
			timeout_q <= srsw_pkg::TIMEOUT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				srsw_pkg::REG_TOTAL:   total_q <= pwdata[srsw_pkg::TOTAL_W-1:0];
				srsw_pkg::REG_WINDOW:  win_q <= pwdata[srsw_pkg::WINREG_W-1:0];
				srsw_pkg::REG_TIMEOUT: timeout_q <= pwdata[srsw_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// window bounds
	always_comb begin
		if (32'(total_q) > srsw_pkg::MAX_PACKETS) begin
			eff_total = BASE_W'(srsw_pkg::MAX_PACKETS);
		end else begin
			eff_total = BASE_W'(total_q);
		end
		if (win_q == '0) begin
			eff_win = END_W'(1);
		end else if (32'(win_q) > srsw_pkg::WIN_CAP) begin
			eff_win = END_W'(srsw_pkg::WIN_CAP);
		end else begin
			eff_win = END_W'(win_q);
		end
		end_raw = END_W'(base_q) + eff_win;
		win_end = (end_raw < END_W'(eff_total)) ? end_raw : END_W'(eff_total);
	end

	assign done       = base_q >= eff_total;
	assign seq_idx    = IDX_W'(seq_q);
	assign idx        = idx_q[IDX_W-1:0];
	assign idx_slot   = idx_q[SLOT_W-1:0];
	assign seq_slot   = seq_idx[SLOT_W-1:0];
	assign base_slot  = base_q[SLOT_W-1:0];
	assign in_win     = (END_W'(seq_q) >= END_W'(base_q)) && (END_W'(seq_q) < win_end);
	assign slide_more = (base_q < eff_total) && acked_q[base_slot];
	assign scan_end   = END_W'(idx_q) >= win_end;

	// entry evaluation
	assign e_acked  = acked_q[idx_slot];
	assign e_sent   = sent_q[idx_slot];
	assign age      = (op_q == srsw_pkg::OP_TICK) && e_sent && !e_acked && (t_rd != '1);
	assign t_aged   = t_rd + TB'(age);
	assign send_now = !e_acked && (!e_sent || (32'(t_aged) >= 32'(timeout_q)));

	// sequencer
	assign uw       = srsw_pkg::ucode(step_q);
	assign out_free = !out_vld_q || rsp.ready;
	assign push_req = (uw.scan_ev && send_now && pend_q) || uw.emit_last;
	assign blocked  = push_req && !out_free;
	assign ev_go    = uw.scan_ev && !blocked;
	assign fin_go   = uw.emit_last && !blocked;
	assign req.ready = uw.take_beat;
	assign beat_in  = req.valid && req.ready;

	always_comb begin
		unique case (uw.jc)
			srsw_pkg::JC_NONE:       jmp = 1'b0;
			srsw_pkg::JC_NO_BEAT:    jmp = !req.valid;
			srsw_pkg::JC_TICK:       jmp = op_q == srsw_pkg::OP_TICK;
			srsw_pkg::JC_SLIDE_MORE: jmp = slide_more;
			srsw_pkg::JC_SCAN_END:   jmp = scan_end;
			srsw_pkg::JC_OUT_BUSY:   jmp = blocked;
			default:                 jmp = 1'b0;
		endcase
	end

	always_comb begin
		step_d = jmp ? uw.alt : uw.nxt;
	end

	// timer memory
	assign t_re    = uw.scan_rd && !scan_end;
	assign t_we    = ev_go && (send_now || age);
	assign t_wdata = send_now ? '0 : t_aged;

	srsw_ram #(
		.WIDTH(TB),
		.DEPTH(srsw_pkg::MAX_PACKETS)
	) u_timer_ram (
		.clk  (clk),
		.we   (t_we),
		.waddr(idx),
		.wdata(t_wdata),
		.re   (t_re),
		.raddr(idx),
		.rdata(t_rd)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= srsw_pkg::ST_IDLE;
			base_q <= '0;
			acked_q <= '0;
			sent_q <= '0;
			out_vld_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (uw.ack_upd && (op_q == srsw_pkg::OP_ACK) && in_win) begin
				acked_q[seq_slot] <= 1'b1;
			end
			// the slot left behind by the base is reused for the new window end
			if (uw.slide && slide_more) begin
				base_q <= base_q + BASE_W'(1);
				acked_q[base_slot] <= 1'b0;
				sent_q[base_slot] <= 1'b0;
			end
			if (ev_go && send_now) begin
				sent_q[idx_slot] <= 1'b1;
				pend_q <= 1'b1;
			end else if (fin_go) begin
				pend_q <= 1'b0;
			end
			if ((ev_go && send_now && pend_q) || fin_go) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (beat_in) begin
			op_q <= req.operation;
			seq_q <= req.ack_seq;
			ign_q <= 1'b0;
			idx_q <= base_q;
		end
		if (uw.ack_upd && (op_q == srsw_pkg::OP_ACK) && !in_win) begin
			ign_q <= 1'b1;
		end
		if (uw.slide && !slide_more) begin
			idx_q <= base_q;
		end
		if (ev_go) begin
			idx_q <= idx_q + BASE_W'(1);
			if (send_now) begin
				pend_seq_q <= idx;
				pend_rt_q <= e_sent;
			end
		end
		if (ev_go && send_now && pend_q) begin
			o_send_q <= 1'b1;
			o_seq_q <= srsw_pkg::SEQ_W'(pend_seq_q);
			o_rt_q <= pend_rt_q;
			o_ign_q <= ign_q;
			o_done_q <= done;
			o_last_q <= 1'b0;
		end else if (fin_go) begin
			o_send_q <= pend_q;
			o_seq_q <= pend_q ? srsw_pkg::SEQ_W'(pend_seq_q) : '0;
			o_rt_q <= pend_q && pend_rt_q;
			o_ign_q <= ign_q;
			o_done_q <= done;
			o_last_q <= 1'b1;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.send_valid    = o_send_q;
	assign rsp.send_seq      = o_seq_q;
	assign rsp.is_retransmit = o_rt_q;
	assign rsp.ack_ignored   = o_ign_q;
	assign rsp.all_done      = o_done_q;
	assign rsp.last          = o_last_q;

endmodule
`default_nettype wire
